FILE: hdl/sfmf_pkg.sv
// Shared types and constants for the substring first-match finder.
package sfmf_pkg;

   localparam int CHAR_W = 16;
   localparam int IDX_W  = 20;
   localparam int CMD_W  = 2;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int CONTENT_MAX_DEF = 1048576;

   // depth of the queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CONTENT = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_value;
      logic [IDX_W-1:0]  start_index;
      logic              last;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   // decoded request as it travels through the queue
   typedef struct packed {
      logic              clear;
      logic              append;
      logic              search;
      logic              content;
      logic              last;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  start_index;
   } op_type;

endpackage

FILE: hdl/sfmf_front.sv
// Front end: accepts requests, decodes them and queues them for the back end.
module sfmf_front import sfmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    q_valid,
   output op_type  q_op,
   input  logic    q_pop
);

   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   op_type          mem_ff [QUEUE_DEPTH];
   logic [QA_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W:0]   rd_ptr_ff, rd_ptr_in;
   op_type          dec_op;
   logic            full, empty, push;

   always_comb begin
      dec_op             = '0;
      dec_op.ch          = req_payload.char_value;
      dec_op.start_index = req_payload.start_index;
      dec_op.last        = req_payload.last;
      case (req_payload.cmd)
         CMD_CLEAR:   dec_op.clear   = 1'b1;
         CMD_APPEND:  dec_op.append  = 1'b1;
         CMD_SEARCH:  dec_op.search  = 1'b1;
         CMD_CONTENT: dec_op.content = 1'b1;
         default:     dec_op.content = 1'b1;
      endcase
   end

   assign empty     = (wr_ptr_ff == rd_ptr_ff);
   assign full      = (wr_ptr_ff[QA_W-1:0] == rd_ptr_ff[QA_W-1:0]) &&
                      (wr_ptr_ff[QA_W] != rd_ptr_ff[QA_W]);
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign q_valid   = !empty;
   assign q_op      = mem_ff[rd_ptr_ff[QA_W-1:0]];

   assign wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[QA_W-1:0]] <= dec_op;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !empty)
      else $error("queue popped while empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      full && !q_pop |=> full)
      else $error("queue lost an entry while full");

endmodule

FILE: hdl/sfmf_back.sv
// Back end: pattern store, text window compare and result register.
module sfmf_back import sfmf_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int CONTENT_MAX = CONTENT_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    ignore_case,
   input  logic    q_valid,
   input  op_type  q_op,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W = $clog2(CONTENT_MAX + 1);

   function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CHAR_W'(16'h0061) && c <= CHAR_W'(16'h007A)) begin
         r = c - CHAR_W'(16'h0020);
      end
      return r;
   endfunction

   // pattern kept reversed: entry 0 holds the last pattern char, so entry j
   // lines up with window entry j (newest char in entry 0)
   logic [CHAR_W-1:0]      pat_ff [PATTERN_MAX];
   logic [CHAR_W-1:0]      win_ff [PATTERN_MAX];
   logic [CHAR_W-1:0]      win_new [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] wv_ff, wv_in, wv_new;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [CNT_W-1:0]       seen_ff, seen_in, seen_new;
   logic [IDX_W-1:0]       base_ff, base_in;
   logic                   active_ff, active_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   go, hit, at_limit, emit, do_append, do_shift;
   rsp_type                emit_rsp;

   assign go    = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = go;

   always_comb begin
      win_new[0] = q_op.ch;
      wv_new[0]  = 1'b1;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_new[k] = win_ff[k-1];
         wv_new[k]  = wv_ff[k-1];
      end
   end

   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (LEN_W'(j) < len_ff) begin
            if (!wv_new[j]) begin
               hit = 1'b0;
            end else if (pat_ff[j] != win_new[j] &&
                         !(ignore_case &&
                           fold_upper(pat_ff[j]) == fold_upper(win_new[j]))) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign seen_new = seen_ff + 1'b1;
   assign at_limit = (seen_new == CNT_W'(CONTENT_MAX));

   always_comb begin
      len_in    = len_ff;
      seen_in   = seen_ff;
      base_in   = base_ff;
      active_in = active_ff;
      wv_in     = wv_ff;
      emit      = 1'b0;
      emit_rsp  = '0;
      do_append = 1'b0;
      do_shift  = 1'b0;
      if (go) begin
         if (q_op.clear && !active_ff) begin
            len_in = '0;
         end
         if (q_op.append && !active_ff && len_ff < LEN_W'(PATTERN_MAX)) begin
            do_append = 1'b1;
            len_in    = len_ff + 1'b1;
         end
         if (q_op.search) begin
            // base minus length so a hit only adds the char count
            base_in   = q_op.start_index - IDX_W'(len_ff);
            seen_in   = '0;
            wv_in     = '0;
            active_in = 1'b0;
            if (len_ff == '0) begin
               emit                 = 1'b1;
               emit_rsp.found       = 1'b1;
               emit_rsp.match_index = q_op.start_index;
            end else if (q_op.last) begin
               emit = 1'b1;
            end else begin
               active_in = 1'b1;
            end
         end
         if (q_op.content && active_ff) begin
            do_shift = 1'b1;
            wv_in    = wv_new;
            seen_in  = seen_new;
            if (hit) begin
               active_in            = 1'b0;
               emit                 = 1'b1;
               emit_rsp.found       = 1'b1;
               emit_rsp.match_index = base_ff + IDX_W'(seen_new);
            end else if (q_op.last || at_limit) begin
               active_in = 1'b0;
               emit      = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (go && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         seen_ff      <= '0;
         base_ff      <= '0;
         active_ff    <= 1'b0;
         wv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         base_ff      <= base_in;
         active_ff    <= active_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (do_append) begin
         pat_ff[0] <= q_op.ch;
         for (int k = 1; k < PATTERN_MAX; k++) begin
            pat_ff[k] <= pat_ff[k-1];
         end
      end
      if (do_shift) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_ff[k] <= win_new[k];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.match_index == '0)
      else $error("not-found result carries an index");

   a_empty_pattern: assert property (@(posedge clock) disable iff (reset)
      go && q_op.search && len_ff == '0 |=> rsp_valid_ff && rsp_ff.found)
      else $error("empty pattern search did not report at once");

   a_active_len: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> len_ff != '0)
      else $error("search active with empty pattern");

   a_len_frozen: assert property (@(posedge clock) disable iff (reset)
      active_ff && $past(active_ff) |-> $stable(len_ff))
      else $error("pattern length changed during a search");

endmodule

FILE: hdl/substring_first_match_finder.sv
// Top level of the substring first-match finder.
//
// Streams 16-bit characters and reports the first place a stored pattern
// occurs. Requests arrive on req_* (valid/stall): clear pattern, append a
// pattern char, begin a search (start_index = absolute index of the first
// content char), or a content char (last marks the final one). Each search
// ends with one rsp_* result, or none if a new search abandons it: found
// with match_index, or not-found with a zero index. An empty pattern
// reports the start index right away. csr_* writes the single ignore_case
// bit; write it only while idle.
// Throughput: one request per cycle while the queue is not full and no
// result waits on rsp_stall, set by the parallel window compare in the back
// end. A request is written into the queue, then executed into the result
// register. A four-entry queue decouples the front end from the back
// end, so requests keep flowing while a result waits on rsp_stall; once the
// queue fills, req_stall rises. Synchronous reset empties the queue, clears
// the pattern length, ends any search and drops a pending result;
// ignore_case returns to 0.
module substring_first_match_finder import sfmf_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int CONTENT_MAX = CONTENT_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   logic   ignore_case_ff, ignore_case_in;
   logic   q_valid, q_pop;
   op_type q_op;

   // register writes always land at once
   assign csr_ready      = 1'b1;
   assign ignore_case_in = (csr_valid && csr_ready) ? csr_wdata : ignore_case_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_case_ff <= 1'b0;
      end else begin
         ignore_case_ff <= ignore_case_in;
      end
   end

   // decode and buffer requests
   sfmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_op        (q_op),
      .q_pop       (q_pop)
   );

   // pattern, window compare, result register
   sfmf_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .CONTENT_MAX (CONTENT_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ignore_case (ignore_case_ff),
      .q_valid     (q_valid),
      .q_op        (q_op),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/sfmf_result_checker.sv
// Checker for the substring first-match finder: tracks requests, predicts and compares results.
`timescale 1ns / 1ps

module sfmf_result_checker import sfmf_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int CONTENT_MAX = CONTENT_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_wdata,
   output int      mismatch_count,
   output int      outcomes_due
);

   localparam logic [CHAR_W-1:0] LOWER_A  = 16'h0061;
   localparam logic [CHAR_W-1:0] LOWER_Z  = 16'h007A;
   localparam logic [CHAR_W-1:0] CASE_GAP = 16'h0020;

   logic [CHAR_W-1:0] pattern_chars [PATTERN_MAX];
   logic [CHAR_W-1:0] recent_chars  [PATTERN_MAX];   // entry 0 is the newest
   int                pattern_len;
   int unsigned       text_count;
   logic [IDX_W-1:0]  text_base;
   logic              searching;
   logic              fold_case;
   rsp_type           awaited_outcomes [$];

   function automatic logic [CHAR_W-1:0] upper_ascii(input logic [CHAR_W-1:0] c);
      return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_GAP : c;
   endfunction

   function automatic logic chars_agree(input logic [CHAR_W-1:0] p,
                                        input logic [CHAR_W-1:0] t);
      return (p == t) || (fold_case && upper_ascii(p) == upper_ascii(t));
   endfunction

   task automatic predict_outcome(input req_type r);
      rsp_type          outcome;
      logic             hit;
      logic [IDX_W-1:0] offset;
      int               k;
      outcome = '0;
      case (r.cmd)
         CMD_CLEAR: begin
            if (!searching) pattern_len = 0;
         end
         CMD_APPEND: begin
            if (!searching && pattern_len < PATTERN_MAX) begin
               pattern_chars[pattern_len] = r.char_value;
               pattern_len++;
            end
         end
         CMD_SEARCH: begin
            text_base  = r.start_index;
            text_count = 0;
            searching  = 1'b0;
            for (k = 0; k < PATTERN_MAX; k++) recent_chars[k] = '0;
            if (pattern_len == 0) begin
               outcome.found       = 1'b1;
               outcome.match_index = r.start_index;
               awaited_outcomes.push_back(outcome);
            end else if (r.last) begin
               awaited_outcomes.push_back(outcome);
            end else begin
               searching = 1'b1;
            end
         end
         default: begin
            if (searching) begin
               for (k = PATTERN_MAX - 1; k > 0; k--) recent_chars[k] = recent_chars[k-1];
               recent_chars[0] = r.char_value;
               text_count++;
               // pattern char k pairs with the window entry len-1-k
               hit = (text_count >= pattern_len);
               for (k = 0; k < pattern_len; k++)
                  if (!chars_agree(pattern_chars[k], recent_chars[pattern_len-1-k])) hit = 1'b0;
               if (hit) begin
                  searching           = 1'b0;
                  offset              = IDX_W'(text_count - pattern_len);
                  outcome.found       = 1'b1;
                  outcome.match_index = text_base + offset;
                  awaited_outcomes.push_back(outcome);
               end else if (r.last || text_count >= CONTENT_MAX) begin
                  searching = 1'b0;
                  awaited_outcomes.push_back(outcome);
               end
            end
         end
      endcase
   endtask

   task automatic check_outcome(input rsp_type got);
      rsp_type want;
      if (awaited_outcomes.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual found=%0b match_index=%h",
                  $time, got.found, got.match_index);
         mismatch_count++;
      end else begin
         want = awaited_outcomes.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
            mismatch_count++;
         end
         if (got.match_index !== want.match_index) begin
            $display("%0t: match_index expected %h actual %h",
                     $time, want.match_index, got.match_index);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_len = 0;
         text_count  = 0;
         text_base   = '0;
         searching   = 1'b0;
         fold_case   = 1'b0;
         foreach (recent_chars[i]) recent_chars[i] = '0;
         awaited_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) fold_case = csr_wdata;
         if (rsp_valid && !rsp_stall) check_outcome(rsp_payload);
         if (req_valid && !req_stall) predict_outcome(req_payload);
      end
      outcomes_due = awaited_outcomes.size();
   end

endmodule

FILE: test/substring_first_match_finder_test.sv
// Testbench top for the substring first-match finder: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module substring_first_match_finder_test;
   import sfmf_pkg::*;

   // run bounds; the limit covers about 1850 requests with worst-case gaps
   // and receiver hold-offs, several times over
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 8;     // queue plus result register, with margin
   localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_wdata;

   int          mismatches;
   int          outcomes_due;
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   bit          sender_idles;
   bit          receiver_idles;
   bit          hold_pending;

   // stimulus-side copy of what was loaded, used to plant occurrences and to force a reload when empty
   logic [CHAR_W-1:0] loaded_pattern [$];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   substring_first_match_finder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   sfmf_result_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .outcomes_due   (outcomes_due)
   );

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request from
   // the stimulus so the queue fills and req_stall rises.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Mostly a small alphabet around the ASCII case-fold boundaries so that
   // occurrences (and near misses) are common; now and then any 16-bit value.
   function automatic logic [CHAR_W-1:0] pick_char();
      case ($urandom_range(0, 13))
         0, 1, 2: return 16'h0061;   // a
         3, 4, 5: return 16'h0041;   // A
         6:       return 16'h0062;   // b
         7:       return 16'h0042;   // B
         8:       return 16'h007A;   // z, top of lower case
         9:       return 16'h005A;   // Z
         10:      return 16'h0060;   // just below lower case
         11:      return 16'h007B;   // just above lower case
         12:      return 16'h0161;   // low byte of 'a', not a letter
         default: return CHAR_W'($urandom);
      endcase
   endfunction

   // Entered at a falling edge. Valid stays high between back-to-back
   // requests; an optional gap comes before the request is offered.
   task automatic send_req(input logic [CMD_W-1:0]  cmd,
                           input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0]  start,
                           input logic              last);
      req_type item;
      item.cmd         = cmd;
      item.char_value  = ch;
      item.start_index = start;
      item.last        = last;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic csr_write(input logic value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering, wait until every predicted result has come back, then
   // let any result-free requests still queued drain out.
   task automatic settle();
      req_valid <= 1'b0;
      while (outcomes_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One well-formed search: optional pattern reload, begin, a short text
   // with an occurrence planted half the time when it fits, then one of several endings.
   // Every ending leaves no search running.
   task automatic run_sequence();
      logic [CHAR_W-1:0] text [$];
      logic [CHAR_W-1:0] c;
      int                n;
      int                at;
      int                ending;
      if (loaded_pattern.size() == 0 || $urandom_range(0, 3) != 0) begin
         send_req(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom), 1'($urandom));
         loaded_pattern.delete();
         case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = $urandom_range(15, 18);   // near or past the store size, extras dropped
            default: n = $urandom_range(1, 5);
         endcase
         repeat (n) begin
            c = pick_char();
            send_req(CMD_APPEND, c, IDX_W'($urandom), 1'($urandom));
            if (loaded_pattern.size() < PATTERN_MAX_DEF) loaded_pattern.push_back(c);
         end
      end
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      repeat (n) text.push_back(pick_char());
      if ($urandom_range(0, 1) == 1 && loaded_pattern.size() > 0
          && loaded_pattern.size() <= n) begin
         at = $urandom_range(0, n - loaded_pattern.size());
         foreach (loaded_pattern[i]) begin
            c = loaded_pattern[i];
            // flip letter case now and then; only matches with ignore_case set
            if ($urandom_range(0, 2) == 0) begin
               if (c >= 16'h0061 && c <= 16'h007A) c = c - 16'h0020;
               else if (c >= 16'h0041 && c <= 16'h005A) c = c + 16'h0020;
            end
            text[at + i] = c;
         end
      end
      send_req(CMD_SEARCH, CHAR_W'($urandom), IDX_W'($urandom), $urandom_range(0, 9) == 0);
      ending = $urandom_range(0, 9);
      foreach (text[i])
         send_req(CMD_CONTENT, text[i], IDX_W'($urandom), ending < 7 && i == n - 1);
      if (ending >= 7 || n == 0) begin
         if (ending == 7) begin
            // pattern edits: dropped if the search still runs, applied if it ended
            repeat ($urandom_range(1, 3))
               send_req($urandom_range(0, 1) ? CMD_CLEAR : CMD_APPEND,
                        CHAR_W'($urandom), IDX_W'($urandom), 1'($urandom));
            loaded_pattern.delete();
         end
         if (ending == 9)   // abandon
            send_req(CMD_SEARCH, CHAR_W'($urandom), IDX_W'($urandom), 1'b0);
         send_req(CMD_SEARCH, CHAR_W'($urandom), IDX_W'($urandom), 1'b1);
      end
   endtask

   initial begin
      int unsigned phase_end;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_valid      = 1'b0;
      csr_wdata      = 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_pending   = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_write(1'b0);

      // --- directed requests ---
      send_req(CMD_SEARCH,  16'h0000, 20'hFFFFF, 1'b0);  // empty pattern: found at start
      send_req(CMD_CONTENT, 16'hFFFF, 20'h00000, 1'b1);  // content while idle: ignored
      send_req(CMD_APPEND,  16'h0061, 20'h00000, 1'b0);  // pattern "aB"
      send_req(CMD_APPEND,  16'h0042, 20'hFFFFF, 1'b1);
      send_req(CMD_SEARCH,  16'hFFFF, 20'hFFFFE, 1'b1);  // begin with last: not found
      send_req(CMD_SEARCH,  16'h0000, 20'hFFFFE, 1'b0);
      send_req(CMD_CLEAR,   16'h0000, 20'h00000, 1'b0);  // edits ignored while searching
      send_req(CMD_APPEND,  16'h0000, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0061, 20'h00000, 1'b0);
      send_req(CMD_SEARCH,  16'h0000, 20'h00000, 1'b0);  // abandon and restart at 0
      send_req(CMD_CONTENT, 16'h0078, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0061, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0042, 20'h00000, 1'b0);  // found at 1
      send_req(CMD_CONTENT, 16'hFFFF, 20'hFFFFF, 1'b0);  // idle again: ignored
      send_req(CMD_SEARCH,  16'h0000, 20'hFFFFF, 1'b0);
      send_req(CMD_CONTENT, 16'h007A, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0061, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0042, 20'h00000, 1'b0);  // index wraps to 0
      send_req(CMD_SEARCH,  16'h0000, 20'h12345, 1'b0);
      send_req(CMD_CONTENT, 16'h0041, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0062, 20'h00000, 1'b1);  // case differs: not found
      settle();
      csr_write(1'b1);
      send_req(CMD_SEARCH,  16'h0000, 20'h12345, 1'b0);
      send_req(CMD_CONTENT, 16'h0041, 20'h00000, 1'b0);
      send_req(CMD_CONTENT, 16'h0062, 20'h00000, 1'b1);  // folded: found at start
      send_req(CMD_CLEAR,   16'h0000, 20'h00000, 1'b0);
      settle();

      // --- random phases, ignore_case alternating; no idling in the last ---
      for (int p = 0; p < PHASES; p++) begin
         sender_idles   = (p != PHASES - 1);
         receiver_idles = (p != PHASES - 1);
         csr_write((p % 2) == 0);
         if (p == 2) begin
            // long receiver hold-off while searches keep producing results
            hold_pending = 1'b1;
            repeat (12) send_req(CMD_SEARCH, CHAR_W'($urandom), IDX_W'($urandom), 1'b1);
         end
         phase_end = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) run_sequence();
         settle();
      end

      if (mismatches == 0 && outcomes_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
